// ===== design/humidity_sensor_frame_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the humidity sensor frame decoder
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_MACROS_SVH

// Checked property, suspended while reset is asserted
`define HSFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked property that also holds through reset
`define HSFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/hsfd_pkg.sv =====
// ---------------------------------------------------------------------------
// hsfd_pkg
// Types, constants and the CRC-8 helper shared by the frame decoder files.
// ---------------------------------------------------------------------------
package hsfd_pkg;

    // CRC-8, polynomial 0x31, start 0xFF, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Frame positions
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_T_CRC   = 2'd1;
    localparam logic [1:0] STATUS_H_CRC   = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

    // Scaling: temp = ((4375*raw)>>14)-4500, hum = (625*raw)>>12
    localparam int TEMP_SCALE  = 4375;
    localparam int TEMP_SHIFT  = 14;
    localparam int TEMP_OFFSET = 4500;
    localparam int HUM_SCALE   = 625;
    localparam int HUM_SHIFT   = 12;
    localparam int TEMP_PROD_W = 29;
    localparam int HUM_PROD_W  = 26;

    // Queue between front and back
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [13:0] humidity_centi;
        logic        [1:0]  status;
    } t_out_word;

    // One decoded frame waiting for scaling
    typedef struct packed {
        logic [15:0] temperature_raw;
        logic [15:0] humidity_raw;
        logic [1:0]  status;
    } t_job;

    // Queue flags seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Absorb one byte into the CRC, eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/hsfd_front.sv =====
// ---------------------------------------------------------------------------
// hsfd_front
// Tracks the frame position, runs the CRC and pushes one job per frame.
// ---------------------------------------------------------------------------
module hsfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hsfd_pkg::t_in_word i_in_word,
    input  hsfd_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output hsfd_pkg::t_job    o_job
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_t_raw, n_t_raw;
    logic [15:0] r_h_raw, n_h_raw;
    logic        r_t_good, n_t_good;
    logic        accept;
    logic [2:0]  pos;
    logic [7:0]  b;

    // Stall only while the queue has no room
    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign b          = i_in_word.data_byte;
    assign pos        = (i_in_word.frame_start || (r_pos > hsfd_pkg::POS_H_CRC))
                        ? hsfd_pkg::POS_T_HI : r_pos;

    // Position decode
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_t_raw  = r_t_raw;
        n_h_raw  = r_h_raw;
        n_t_good = r_t_good;
        o_push   = 1'b0;
        o_job.temperature_raw = r_t_raw;
        o_job.humidity_raw    = r_h_raw;
        if (!r_t_good) begin
            o_job.status = hsfd_pkg::STATUS_T_CRC;
        end else if (r_crc != b) begin
            o_job.status = hsfd_pkg::STATUS_H_CRC;
        end else begin
            o_job.status = hsfd_pkg::STATUS_OK;
        end
        if (accept) begin
            unique case (pos)
                hsfd_pkg::POS_T_HI: begin
                    n_t_raw = {b, 8'h00};
                    n_crc   = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, b);
                    n_pos   = hsfd_pkg::POS_T_LO;
                end
                hsfd_pkg::POS_T_LO: begin
                    n_t_raw = {r_t_raw[15:8], b};
                    n_crc   = hsfd_pkg::crc8_byte(r_crc, b);
                    n_pos   = hsfd_pkg::POS_T_CRC;
                end
                hsfd_pkg::POS_T_CRC: begin
                    n_t_good = (r_crc == b);
                    n_crc    = hsfd_pkg::CRC_INIT;
                    n_pos    = hsfd_pkg::POS_H_HI;
                end
                hsfd_pkg::POS_H_HI: begin
                    n_h_raw = {b, 8'h00};
                    n_crc   = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, b);
                    n_pos   = hsfd_pkg::POS_H_LO;
                end
                hsfd_pkg::POS_H_LO: begin
                    n_h_raw = {r_h_raw[15:8], b};
                    n_crc   = hsfd_pkg::crc8_byte(r_crc, b);
                    n_pos   = hsfd_pkg::POS_H_CRC;
                end
                default: begin
                    o_push = 1'b1;
                    n_crc  = hsfd_pkg::CRC_INIT;
                    n_pos  = hsfd_pkg::POS_T_HI;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= hsfd_pkg::POS_T_HI;
            r_crc    <= hsfd_pkg::CRC_INIT;
            r_t_raw  <= 16'h0000;
            r_h_raw  <= 16'h0000;
            r_t_good <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_t_raw  <= n_t_raw;
            r_h_raw  <= n_h_raw;
            r_t_good <= n_t_good;
        end
    end

endmodule

// ===== design/hsfd_queue.sv =====
// ---------------------------------------------------------------------------
// hsfd_queue
// Short first-in first-out queue of decoded frames between front and back.
// ---------------------------------------------------------------------------
module hsfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hsfd_pkg::t_job    i_job,
    input  logic              i_pop,
    output hsfd_pkg::t_job    o_job,
    output hsfd_pkg::t_q_stat o_q_stat
);

    localparam int CntW = hsfd_pkg::QUEUE_PTR_W + 1;

    hsfd_pkg::t_job                   r_mem [hsfd_pkg::QUEUE_DEPTH];
    logic [hsfd_pkg::QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [CntW-1:0]                  r_cnt;
    logic                             do_push, do_pop;

    assign o_q_stat.full  = (r_cnt == CntW'(hsfd_pkg::QUEUE_DEPTH));
    assign o_q_stat.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_q_stat.full;
    assign do_pop         = i_pop && !o_q_stat.empty;
    assign o_job          = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(do_push) - CntW'(do_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== design/hsfd_back.sv =====
// ---------------------------------------------------------------------------
// hsfd_back
// Scales the raw values in two stages and holds the result word.
// ---------------------------------------------------------------------------
module hsfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsfd_pkg::t_q_stat   i_q_stat,
    input  hsfd_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hsfd_pkg::t_out_word o_out_word
);

    logic                           r_s1_valid;
    logic [hsfd_pkg::TEMP_PROD_W-1:0] r_t_prod;
    logic [hsfd_pkg::HUM_PROD_W-1:0]  r_h_prod;
    logic [1:0]                     r_s1_status;
    logic                           r_out_valid;
    hsfd_pkg::t_out_word            r_out_word, n_out_word;
    logic                           s1_move, s1_load;
    logic [15:0]                    t_sum;

    // Handshake between stages
    assign s1_move = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_load = !i_q_stat.empty && (!r_s1_valid || s1_move);
    assign o_pop   = s1_load;

    // Final shift, offset and zeroing on a bad CRC
    always_comb begin
        t_sum = 16'(r_t_prod >> hsfd_pkg::TEMP_SHIFT) - 16'(hsfd_pkg::TEMP_OFFSET);
        n_out_word.status = r_s1_status;
        if (r_s1_status == hsfd_pkg::STATUS_OK) begin
            n_out_word.temperature_centi = t_sum[14:0];
            n_out_word.humidity_centi    = 14'(r_h_prod >> hsfd_pkg::HUM_SHIFT);
        end else begin
            n_out_word.temperature_centi = '0;
            n_out_word.humidity_centi    = '0;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payloads: products, then result word
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_t_prod <= hsfd_pkg::TEMP_PROD_W'(hsfd_pkg::TEMP_SCALE)
                        * hsfd_pkg::TEMP_PROD_W'(i_job.temperature_raw);
            r_h_prod <= hsfd_pkg::HUM_PROD_W'(hsfd_pkg::HUM_SCALE)
                        * hsfd_pkg::HUM_PROD_W'(i_job.humidity_raw);
            r_s1_status <= i_job.status;
        end
        if (s1_move) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== design/humidity_sensor_frame_decoder.sv =====
// ---------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes six-byte temperature and humidity sensor replies into scaled values.
// ---------------------------------------------------------------------------
// Input channel: one reply byte per word (i_in_valid / o_in_stall); frame_start
// marks byte one and drops any partial frame. Bytes are taken one per cycle unless stalled.
// Output channel: one word per complete frame (o_out_valid / i_out_stall) with
// temperature in 0.01 C, humidity in 0.01 %RH and a CRC status; both values
// read zero when the status is not ok.
// After the edge that takes the sixth byte, the frame passes through the queue,
// the product stage and the output register before the result is valid.
// Throughput: one byte per cycle while o_in_stall is low, bounded by the front's
// CRC and position update; the back takes a new frame as the previous one moves on.
// A two-entry queue sits between front and back. When the receiver stalls, the
// output word holds, the back fills, then the queue; o_in_stall rises only
// once the queue is full.
// Reset clears the frame position, the CRC to 0xFF, the raw values, the queue
// and all valid flags.
// ---------------------------------------------------------------------------
`include "humidity_sensor_frame_decoder_macros.svh"

module humidity_sensor_frame_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hsfd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hsfd_pkg::t_out_word o_out_word
);

    hsfd_pkg::t_q_stat q_stat;
    hsfd_pkg::t_job    push_job, pop_job;
    logic              push, pop;

    // Front: frame parser and CRC
    hsfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Queue of decoded frames
    hsfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_q_stat (q_stat)
    );

    // Back: scaling and output register
    hsfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Checks
    `HSFD_ASSERT(a_bad_crc_zero, i_clk, i_rst_n, (o_out_valid && (o_out_word.status != hsfd_pkg::STATUS_OK)) |-> ((o_out_word.temperature_centi == '0) && (o_out_word.humidity_centi == '0)), "bad CRC word carries nonzero values")
    `HSFD_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_out_word.status != hsfd_pkg::STATUS_INVALID), "unused status code")
    `HSFD_ASSERT(a_no_push_full, i_clk, i_rst_n, push |-> !q_stat.full, "frame pushed into full queue")
    `HSFD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
